### sv/owned_channel_byte_pipe_table_defines.svh
// ----------------------------------------------------------------------------
// owned_channel_byte_pipe_table_defines
// assertion macros used by the channel table controller rtl
// ----------------------------------------------------------------------------
`ifndef OWNED_CHANNEL_BYTE_PIPE_TABLE_DEFINES_SVH
`define OWNED_CHANNEL_BYTE_PIPE_TABLE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define OCB_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication outside reset
`define OCB_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### sv/ocbpt_pkg.sv
// ----------------------------------------------------------------------------
// ocbpt_pkg
// shared types and codes for the owned channel byte pipe table
// ----------------------------------------------------------------------------
`default_nettype none
package ocbpt_pkg;
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_MWRITE  = 3'd2;
  localparam logic [2:0] OP_MREAD   = 3'd3;
  localparam logic [2:0] OP_SWRITE  = 3'd4;
  localparam logic [2:0] OP_SREAD   = 3'd5;
  localparam logic [2:0] OP_CLEANUP = 3'd6;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_NOFREE = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  channel;
    logic [15:0] caller_pid;
    logic [7:0]  data_in;
    logic        last_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  channel_out;
    logic [7:0]  data_out;
    logic [15:0] transfer_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, read pointers
    logic mem_rd;   // issue ring read
    logic execute;  // update table, write ring, build response
  } cmd_t;
endpackage
`default_nettype wire

### sv/ocbpt_if.sv
// ----------------------------------------------------------------------------
// ocbpt_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface ocbpt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/ocbpt_ctrl.sv
// ----------------------------------------------------------------------------
// ocbpt_ctrl
// sequencer: load, ring read, execute, hold response
// ----------------------------------------------------------------------------
`default_nettype none
`include "owned_channel_byte_pipe_table_defines.svh"
module ocbpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      ocbpt_pkg::cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid_next;

  // response register frees the sequencer once taken or empty
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute    = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `OCB_ASSERT_NEXT(a_load_then_read, clk, rst, cmd.load, state == S_READ, "load not followed by read")
  `OCB_ASSERT_NEXT(a_exec_gives_rsp, clk, rst, cmd.execute, out_valid, "execute lost response")
  `OCB_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ready, "accept while busy")
endmodule
`default_nettype wire

### sv/ocbpt_datapath.sv
// ----------------------------------------------------------------------------
// ocbpt_datapath
// channel table, ring pointers, ring memories and running count
// ----------------------------------------------------------------------------
`default_nettype none
module ocbpt_datapath #(
  parameter int CHANNELS   = 8,
  parameter int RING_DEPTH = 2048,
  parameter int PID_WIDTH  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ocbpt_pkg::cmd_t   cmd,
  input  wire ocbpt_pkg::req_t   req_in,
  output      ocbpt_pkg::rsp_t   rsp
);
  localparam int PW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW  = CW + PW;
  localparam int MEM_DEPTH = 2 ** MW;
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  ocbpt_pkg::req_t req;
  logic                 slot_used  [CHANNELS];
  logic [PID_WIDTH-1:0] slot_owner [CHANNELS];
  logic [PW-1:0] ts_head [CHANNELS];
  logic [PW-1:0] ts_tail [CHANNELS];
  logic [PW-1:0] tm_head [CHANNELS];
  logic [PW-1:0] tm_tail [CHANNELS];
  logic [15:0]   running_count;

  logic [7:0] ts_mem [MEM_DEPTH];
  logic [7:0] tm_mem [MEM_DEPTH];
  logic [7:0] ts_rd, tm_rd;

  // decoded request, registered at load
  logic          ch_ok;
  logic [CW-1:0] ch;
  logic          used_q, own_q;
  logic [PW-1:0] ts_h, ts_t, tm_h, tm_t;
  logic [PID_WIDTH-1:0] pid;

  assign pid = PID_WIDTH'(req_in.caller_pid);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req    <= req_in;
      ch     <= CW'(req_in.channel);
      ch_ok  <= 32'(req_in.channel) < CHANNELS;
      used_q <= (32'(req_in.channel) < CHANNELS) && slot_used[CW'(req_in.channel)];
      own_q  <= slot_owner[CW'(req_in.channel)] == pid;
      ts_h   <= ts_head[CW'(req_in.channel)];
      ts_t   <= ts_tail[CW'(req_in.channel)];
      tm_h   <= tm_head[CW'(req_in.channel)];
      tm_t   <= tm_tail[CW'(req_in.channel)];
    end
  end

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  // ring read at head (registered memory read)
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      ts_rd <= ts_mem[{ch, ts_h}];
      tm_rd <= tm_mem[{ch, tm_h}];
    end
  end

  logic valid_ch, owner_ok, is_xfer, slave_op;
  logic [2:0] status;
  logic [2:0] ch_out;
  logic [7:0] dout;
  logic       ts_push, ts_pop, tm_push, tm_pop, do_clear, do_create;
  logic [CW-1:0] free_idx;
  logic       free_any;
  logic [15:0] cnt_new;

  assign valid_ch = ch_ok && used_q;
  assign owner_ok = valid_ch && own_q;

  // lowest free channel
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_idx = CW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    status = ocbpt_pkg::ST_OK;
    ch_out = '0;
    dout = '0;
    ts_push = 1'b0; ts_pop = 1'b0; tm_push = 1'b0; tm_pop = 1'b0;
    do_clear = 1'b0; do_create = 1'b0;
    is_xfer = 1'b0; slave_op = 1'b0;
    unique case (req.op)
      ocbpt_pkg::OP_CREATE: begin
        if (free_any) begin
          do_create = 1'b1;
          ch_out = 3'(free_idx);
        end else status = ocbpt_pkg::ST_NOFREE;
      end
      ocbpt_pkg::OP_DESTROY: begin
        if (owner_ok) do_clear = 1'b1;
        else status = ocbpt_pkg::ST_REJECT;
      end
      ocbpt_pkg::OP_MWRITE: begin
        is_xfer = 1'b1;
        if (!owner_ok) status = ocbpt_pkg::ST_REJECT;
        else if (nxt(ts_t) == ts_h) status = ocbpt_pkg::ST_FULL;
        else ts_push = 1'b1;
      end
      ocbpt_pkg::OP_MREAD: begin
        is_xfer = 1'b1;
        if (!owner_ok) status = ocbpt_pkg::ST_REJECT;
        else if (tm_h == tm_t) status = ocbpt_pkg::ST_EMPTY;
        else begin
          tm_pop = 1'b1;
          dout = tm_rd;
        end
      end
      ocbpt_pkg::OP_SWRITE: begin
        is_xfer = 1'b1; slave_op = 1'b1;
        if (!valid_ch) status = ocbpt_pkg::ST_REJECT;
        else if (nxt(tm_t) == tm_h) status = ocbpt_pkg::ST_FULL;
        else tm_push = 1'b1;
      end
      ocbpt_pkg::OP_SREAD: begin
        is_xfer = 1'b1; slave_op = 1'b1;
        if (!valid_ch) status = ocbpt_pkg::ST_REJECT;
        else if (ts_h == ts_t) status = ocbpt_pkg::ST_EMPTY;
        else begin
          ts_pop = 1'b1;
          dout = ts_rd;
        end
      end
      ocbpt_pkg::OP_CLEANUP: status = ocbpt_pkg::ST_OK;
      default: status = ocbpt_pkg::ST_REJECT;
    endcase
  end

  assign cnt_new = (is_xfer && status == ocbpt_pkg::ST_OK && running_count != 16'hFFFF)
                 ? running_count + 16'd1 : running_count;

  // ring writes at tail
  always_ff @(posedge clk) begin
    if (cmd.execute && ts_push) ts_mem[MW'({ch, ts_t})] <= req.data_in;
    if (cmd.execute && tm_push) tm_mem[MW'({ch, tm_t})] <= req.data_in;
  end

  // table, pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_used[i]  <= 1'b0;
        slot_owner[i] <= '0;
        ts_head[i] <= '0; ts_tail[i] <= '0;
        tm_head[i] <= '0; tm_tail[i] <= '0;
      end
      running_count <= '0;
    end else if (cmd.execute) begin
      if (ts_push) ts_tail[ch] <= nxt(ts_t);
      if (ts_pop)  ts_head[ch] <= nxt(ts_h);
      if (tm_push) tm_tail[ch] <= nxt(tm_t);
      if (tm_pop)  tm_head[ch] <= nxt(tm_h);
      if (do_clear) begin
        slot_used[ch] <= 1'b0; slot_owner[ch] <= '0;
        ts_head[ch] <= '0; ts_tail[ch] <= '0;
        tm_head[ch] <= '0; tm_tail[ch] <= '0;
      end
      if (do_create) begin
        slot_used[free_idx] <= 1'b1;
        slot_owner[free_idx] <= PID_WIDTH'(req.caller_pid);
        ts_head[free_idx] <= '0; ts_tail[free_idx] <= '0;
        tm_head[free_idx] <= '0; tm_tail[free_idx] <= '0;
      end
      if (req.op == ocbpt_pkg::OP_CLEANUP) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (slot_used[i] && slot_owner[i] == PID_WIDTH'(req.caller_pid)) begin
            slot_used[i] <= 1'b0; slot_owner[i] <= '0;
            ts_head[i] <= '0; ts_tail[i] <= '0;
            tm_head[i] <= '0; tm_tail[i] <= '0;
          end
        end
      end
      if (is_xfer && req.last_byte &&
          !(slave_op && (status == ocbpt_pkg::ST_EMPTY || status == ocbpt_pkg::ST_FULL)))
        running_count <= '0;
      else
        running_count <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp.status         <= status;
      rsp.channel_out    <= ch_out;
      rsp.data_out       <= dout;
      rsp.transfer_count <= cnt_new;
    end
  end
endmodule
`default_nettype wire

### sv/owned_channel_byte_pipe_table.sv
// ----------------------------------------------------------------------------
// owned_channel_byte_pipe_table
// owned channel table with two byte rings per channel
// ----------------------------------------------------------------------------
// Each request passes through capture with pointer lookup, a registered ring
// memory read at the head pointer, then execute with table update and ring
// write. The response sits in an output register; the next request is
// taken once the sequencer is idle and that register is free or being taken.
// Ring memories need no clearing after reset; only filled entries are returned.
`default_nettype none
module owned_channel_byte_pipe_table #(
  parameter int CHANNELS   = 8,
  parameter int RING_DEPTH = 2048,
  parameter int PID_WIDTH  = 16
) (
  input wire logic clk,
  input wire logic rst,
  ocbpt_if.sink    in_ch,
  ocbpt_if.source  out_ch
);
  ocbpt_pkg::cmd_t cmd;
  ocbpt_pkg::rsp_t rsp;

  ocbpt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd)
  );

  ocbpt_datapath #(
    .CHANNELS(CHANNELS), .RING_DEPTH(RING_DEPTH), .PID_WIDTH(PID_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req_in(in_ch.payload), .rsp(rsp)
  );

  assign out_ch.payload = rsp;
endmodule
`default_nettype wire
